/* hdl/imh_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed min-heap package
// Shared types, sizes and codes for the indexed binary min-heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imh_pkg;

    localparam int NUM_IDS   = 256;
    localparam int KEY_WIDTH = 32;
    localparam int ID_W      = 8;
    localparam int CNT_W     = 9;
    localparam int OP_W      = 5;
    localparam int ST_W      = 4;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;
    localparam logic [1:0] ACT_PEEK   = 2'd3;

    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_NOTLOW = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;
    localparam logic [1:0] STAT_ABSENT = 2'd3;

    localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT  = 5'd1;
    localparam logic [OP_W-1:0] OP_KEYRD   = 5'd2;
    localparam logic [OP_W-1:0] OP_NEW     = 5'd3;
    localparam logic [OP_W-1:0] OP_DEC     = 5'd4;
    localparam logic [OP_W-1:0] OP_ST1     = 5'd5;
    localparam logic [OP_W-1:0] OP_ST2     = 5'd6;
    localparam logic [OP_W-1:0] OP_ST3     = 5'd7;
    localparam logic [OP_W-1:0] OP_REMINIT = 5'd8;
    localparam logic [OP_W-1:0] OP_REMDO   = 5'd9;
    localparam logic [OP_W-1:0] OP_REMLD   = 5'd10;
    localparam logic [OP_W-1:0] OP_UPRD    = 5'd11;
    localparam logic [OP_W-1:0] OP_UPMV    = 5'd12;
    localparam logic [OP_W-1:0] OP_DNRDL   = 5'd13;
    localparam logic [OP_W-1:0] OP_DNL     = 5'd14;
    localparam logic [OP_W-1:0] OP_DNR     = 5'd15;
    localparam logic [OP_W-1:0] OP_DNMV    = 5'd16;
    localparam logic [OP_W-1:0] OP_FIN     = 5'd17;
    localparam logic [OP_W-1:0] OP_OUT     = 5'd18;

    typedef struct packed {
        logic [1:0]           action;
        logic [ID_W-1:0]      item_id;
        logic [KEY_WIDTH-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ID_W-1:0]      min_id;
        logic [KEY_WIDTH-1:0] min_priority;
        logic                 is_empty;
        logic [CNT_W-1:0]     entry_count;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [KEY_WIDTH-1:0] key;
    } heap_ent_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       found;
        logic       full;
        logic       zero;
        logic       last;
        logic       pos_one;
        logic       no_child;
        logic       has_right;
        logic       key_lower;
        logic       up_swap;
        logic       dn_swap;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* hdl/imh_ctrl.sv */
// ----------------------------------------------------------------------------
// Indexed min-heap controller
// Sequences lookup, removal, sift-up, sift-down and result load per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imh_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire imh_pkg::dp_status_t sts,
    output imh_pkg::cmd_t           cmd
);
    import imh_pkg::*;

    localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] S_LOOK   = 4'd1;
    localparam logic [ST_W-1:0] S_KEYCMP = 4'd2;
    localparam logic [ST_W-1:0] S_REM    = 4'd3;
    localparam logic [ST_W-1:0] S_REMLD  = 4'd4;
    localparam logic [ST_W-1:0] S_UP     = 4'd5;
    localparam logic [ST_W-1:0] S_UPCMP  = 4'd6;
    localparam logic [ST_W-1:0] S_DOWN   = 4'd7;
    localparam logic [ST_W-1:0] S_DNL    = 4'd8;
    localparam logic [ST_W-1:0] S_DNR    = 4'd9;
    localparam logic [ST_W-1:0] S_DNCMP  = 4'd10;
    localparam logic [ST_W-1:0] S_FIN    = 4'd11;
    localparam logic [ST_W-1:0] S_DONE   = 4'd12;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                unique case (sts.act)
                    ACT_INSERT:
                    begin
                        if (sts.found)
                        begin
                            cmd.op     = OP_KEYRD;
                            state_next = S_KEYCMP;
                        end
                        else if (sts.full)
                        begin
                            cmd.op     = OP_ST2;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_NEW;
                            state_next = S_UP;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (sts.found)
                        begin
                            cmd.op     = OP_REMINIT;
                            state_next = S_REM;
                        end
                        else
                        begin
                            cmd.op     = OP_ST3;
                            state_next = S_DONE;
                        end
                    end
                    ACT_POP:
                    begin
                        if (sts.zero)
                        begin
                            cmd.op     = OP_ST3;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_REMINIT;
                            state_next = S_REM;
                        end
                    end
                    default:
                    begin
                        cmd.op     = sts.zero ? OP_ST3 : OP_NOP;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_KEYCMP:
            begin
                cmd.op     = sts.key_lower ? OP_DEC : OP_ST1;
                state_next = sts.key_lower ? S_UP : S_DONE;
            end
            S_REM:
            begin
                cmd.op     = OP_REMDO;
                state_next = sts.last ? S_DONE : S_REMLD;
            end
            S_REMLD:
            begin
                cmd.op     = OP_REMLD;
                state_next = S_UP;
            end
            S_UP:
            begin
                if (sts.pos_one)
                begin
                    state_next = S_DOWN;
                end
                else
                begin
                    cmd.op     = OP_UPRD;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                cmd.op     = sts.up_swap ? OP_UPMV : OP_NOP;
                state_next = sts.up_swap ? S_UP : S_DOWN;
            end
            S_DOWN:
            begin
                if (sts.no_child)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_DNRDL;
                    state_next = S_DNL;
                end
            end
            S_DNL:
            begin
                cmd.op     = OP_DNL;
                state_next = sts.has_right ? S_DNR : S_DNCMP;
            end
            S_DNR:
            begin
                cmd.op     = OP_DNR;
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                cmd.op     = sts.dn_swap ? OP_DNMV : OP_NOP;
                state_next = sts.dn_swap ? S_DOWN : S_FIN;
            end
            S_FIN:
            begin
                cmd.op     = OP_FIN;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/imh_datapath.sv */
// ----------------------------------------------------------------------------
// Indexed min-heap datapath
// Heap and position memories, the moving entry, counters and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imh_datapath (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire imh_pkg::req_t req,
    input  wire imh_pkg::cmd_t cmd,
    output imh_pkg::dp_status_t sts,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output imh_pkg::rsp_t     rsp
);
    import imh_pkg::*;

    heap_ent_t heap_mem [NUM_IDS];
    logic [CNT_W-1:0] slot_mem [NUM_IDS];
    logic [NUM_IDS-1:0] slot_vld_reg;

    req_t             item_reg;
    heap_ent_t        heap_q_reg;
    logic [CNT_W-1:0] slot_q_reg;
    logic             slot_vld_q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] chpos_reg;
    heap_ent_t        mov_reg;
    heap_ent_t        ch_reg;
    heap_ent_t        root_reg;
    logic [ID_W-1:0]  rem_id_reg;
    logic             pop_reg;
    heap_ent_t        pop_ent_reg;
    logic [1:0]       status_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             heap_we;
    logic [ID_W-1:0]  heap_waddr;
    heap_ent_t        heap_wdata;
    logic             heap_re;
    logic [ID_W-1:0]  heap_raddr;
    logic             slot_we;
    logic [ID_W-1:0]  slot_waddr;
    logic [CNT_W-1:0] slot_wdata;

    logic [CNT_W-1:0] pos_m1;
    logic [CNT_W-1:0] par_m1;
    logic [CNT_W-1:0] two_pos;
    logic [CNT_W-1:0] left_m1;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] slot_m1;

    assign pos_m1  = pos_reg - 9'd1;
    assign par_m1  = (pos_reg >> 1) - 9'd1;
    assign two_pos = {pos_reg[ID_W-1:0], 1'b0};
    assign left_m1 = two_pos - 9'd1;
    assign cnt_m1  = cnt_reg - 9'd1;
    assign slot_m1 = slot_q_reg - 9'd1;

    assign sts.act       = item_reg.action;
    assign sts.found     = slot_vld_q_reg && (slot_q_reg != '0);
    assign sts.full      = (cnt_reg == CNT_W'(NUM_IDS));
    assign sts.zero      = (cnt_reg == '0);
    assign sts.last      = (pos_reg == cnt_reg);
    assign sts.pos_one   = (pos_reg == 9'd1);
    assign sts.no_child  = ({pos_reg, 1'b0} > {1'b0, cnt_reg});
    assign sts.has_right = ({pos_reg, 1'b1} <= {1'b0, cnt_reg});
    assign sts.key_lower = (item_reg.priority_req < heap_q_reg.key);
    assign sts.up_swap   = (heap_q_reg.key > mov_reg.key);
    assign sts.dn_swap   = (ch_reg.key < mov_reg.key);
    assign sts.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        heap_we    = 1'b0;
        heap_waddr = pos_m1[ID_W-1:0];
        heap_wdata = mov_reg;
        heap_re    = 1'b0;
        heap_raddr = pos_m1[ID_W-1:0];
        slot_we    = 1'b0;
        slot_waddr = mov_reg.id;
        slot_wdata = pos_reg;
        case (cmd.op)
            OP_KEYRD:
            begin
                heap_re    = 1'b1;
                heap_raddr = slot_m1[ID_W-1:0];
            end
            OP_REMDO:
            begin
                heap_re    = 1'b1;
                heap_raddr = cnt_m1[ID_W-1:0];
                slot_we    = 1'b1;
                slot_waddr = rem_id_reg;
                slot_wdata = '0;
            end
            OP_UPRD:
            begin
                heap_re    = 1'b1;
                heap_raddr = par_m1[ID_W-1:0];
            end
            OP_UPMV:
            begin
                heap_we    = 1'b1;
                heap_wdata = heap_q_reg;
                slot_we    = 1'b1;
                slot_waddr = heap_q_reg.id;
            end
            OP_DNRDL:
            begin
                heap_re    = 1'b1;
                heap_raddr = left_m1[ID_W-1:0];
            end
            OP_DNL:
            begin
                heap_re    = 1'b1;
                heap_raddr = two_pos[ID_W-1:0];
            end
            OP_DNMV:
            begin
                heap_we    = 1'b1;
                heap_wdata = ch_reg;
                slot_we    = 1'b1;
                slot_waddr = ch_reg.id;
            end
            OP_FIN:
            begin
                heap_we = 1'b1;
                slot_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        if (heap_re)
        begin
            heap_q_reg <= heap_mem[heap_raddr];
        end
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (cmd.op == OP_ACCEPT)
        begin
            slot_q_reg <= slot_mem[req.item_id];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg   <= '0;
            slot_vld_q_reg <= 1'b0;
            cnt_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (slot_we)
            begin
                slot_vld_reg[slot_waddr] <= 1'b1;
            end
            if (cmd.op == OP_ACCEPT)
            begin
                slot_vld_q_reg <= slot_vld_reg[req.item_id];
            end
            if (cmd.op == OP_NEW)
            begin
                cnt_reg <= cnt_reg + 9'd1;
            end
            else if (cmd.op == OP_REMDO)
            begin
                cnt_reg <= cnt_m1;
            end
            if (cmd.op == OP_OUT)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (heap_we && (heap_waddr == '0))
        begin
            root_reg <= heap_wdata;
        end
        case (cmd.op)
            OP_ACCEPT:
            begin
                item_reg   <= req;
                status_reg <= STAT_DONE;
                pop_reg    <= 1'b0;
            end
            OP_NEW:
            begin
                pos_reg <= cnt_reg + 9'd1;
                mov_reg <= '{id: item_reg.item_id, key: item_reg.priority_req};
            end
            OP_DEC:
            begin
                pos_reg <= slot_q_reg;
                mov_reg <= '{id: item_reg.item_id, key: item_reg.priority_req};
            end
            OP_ST1:
            begin
                status_reg <= STAT_NOTLOW;
            end
            OP_ST2:
            begin
                status_reg <= STAT_FULL;
            end
            OP_ST3:
            begin
                status_reg <= STAT_ABSENT;
            end
            OP_REMINIT:
            begin
                if (item_reg.action == ACT_POP)
                begin
                    pos_reg     <= 9'd1;
                    rem_id_reg  <= root_reg.id;
                    pop_reg     <= 1'b1;
                    pop_ent_reg <= root_reg;
                end
                else
                begin
                    pos_reg    <= slot_q_reg;
                    rem_id_reg <= item_reg.item_id;
                end
            end
            OP_REMLD:
            begin
                mov_reg <= heap_q_reg;
            end
            OP_UPMV:
            begin
                pos_reg <= pos_reg >> 1;
            end
            OP_DNL:
            begin
                ch_reg    <= heap_q_reg;
                chpos_reg <= two_pos;
            end
            OP_DNR:
            begin
                if (heap_q_reg.key < ch_reg.key)
                begin
                    ch_reg    <= heap_q_reg;
                    chpos_reg <= chpos_reg + 9'd1;
                end
            end
            OP_DNMV:
            begin
                pos_reg <= chpos_reg;
            end
            OP_OUT:
            begin
                rsp_reg.status      <= status_reg;
                rsp_reg.is_empty    <= (cnt_reg == '0);
                rsp_reg.entry_count <= cnt_reg;
                if (pop_reg)
                begin
                    rsp_reg.min_id       <= pop_ent_reg.id;
                    rsp_reg.min_priority <= pop_ent_reg.key;
                end
                else if (cnt_reg != '0)
                begin
                    rsp_reg.min_id       <= root_reg.id;
                    rsp_reg.min_priority <= root_reg.key;
                end
                else
                begin
                    rsp_reg.min_id       <= '0;
                    rsp_reg.min_priority <= '0;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/indexed_min_heap.sv */
// ----------------------------------------------------------------------------
// Indexed binary min-heap
// Insert or decrease key, remove by id, pop minimum and peek on 256 ids.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  req     | req_valid, req_stall | req_t: action, item_id, priority_req
//  rsp     | rsp_valid, rsp_stall | rsp_t: status, min_id, min_priority,
//          |                      |        is_empty, entry_count
//
// One beat at a time: a request is taken only in idle, and its result is loaded
// before the next is taken. Sift-up reads the parent and moves it down if its key
// is greater; sift-down reads the left child, then the right child if there is
// one, and moves the smaller up; reads go one at a time through the single read port.
// Reset clears the count and the position valid bits at once; no sweep.
// A waiting result sits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_min_heap (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire imh_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output imh_pkg::rsp_t      rsp
);
    import imh_pkg::*;

    cmd_t       cmd;
    dp_status_t sts;

    imh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    imh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

/* hdl/imh_checker.sv */
// ----------------------------------------------------------------------------
// Indexed min-heap checker
// Port-level properties of the heap, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imh_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_stall,
    input wire imh_pkg::req_t req,
    input wire logic          rsp_valid,
    input wire logic          rsp_stall,
    input wire imh_pkg::rsp_t rsp
);
    import imh_pkg::*;

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.entry_count <= CNT_W'(NUM_IDS)))
        else $error("entry_count above capacity");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STAT_FULL)) |-> (rsp.entry_count == CNT_W'(NUM_IDS)))
        else $error("full status with free slots");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while busy");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

endmodule

bind indexed_min_heap imh_checker u_imh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// Indexed min-heap testbench
// Drives insert, decrease, remove, pop and peek beats into the heap, predicts
// every response with a behavioral heap of its own and compares each field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import imh_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic [ID_W-1:0]      model_ids [1:NUM_IDS];
    logic [KEY_WIDTH-1:0] model_keys [1:NUM_IDS];
    int                   model_slot [0:NUM_IDS-1];
    int                   model_count = 0;

    rsp_t expected_rsps[$];
    int   mismatches = 0;
    int   rsps_seen = 0;
    int   beats_sent = 0;
    int   cycles = 0;
    bit   idle_on = 1'b1;
    bit   hold_rsp = 1'b0;
    int   hold_cycles = 0;

    indexed_min_heap DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void swap_entries(int a, int b);
        logic [ID_W-1:0]      ti;
        logic [KEY_WIDTH-1:0] tk;
        ti = model_ids[a];
        tk = model_keys[a];
        model_ids[a] = model_ids[b];
        model_keys[a] = model_keys[b];
        model_ids[b] = ti;
        model_keys[b] = tk;
        model_slot[model_ids[a]] = a;
        model_slot[model_ids[b]] = b;
    endfunction

    function automatic void bubble_up(int p);
        while (p > 1 && model_keys[p / 2] > model_keys[p])
        begin
            swap_entries(p / 2, p);
            p = p / 2;
        end
    endfunction

    function automatic void bubble_down(int p);
        int c;
        forever
        begin
            c = 2 * p;
            if (c > model_count)
                break;
            if (c + 1 <= model_count && model_keys[c + 1] < model_keys[c])
                c++;
            if (model_keys[c] < model_keys[p])
            begin
                swap_entries(p, c);
                p = c;
            end
            else
                break;
        end
    endfunction

    function automatic void drop_slot(int p);
        int last;
        last = model_count;
        model_slot[model_ids[p]] = 0;
        model_count--;
        if (p != last)
        begin
            model_ids[p] = model_ids[last];
            model_keys[p] = model_keys[last];
            model_slot[model_ids[p]] = p;
            bubble_up(p);
            bubble_down(model_slot[model_ids[p]]);
        end
    endfunction

    function automatic rsp_t heap_response(req_t r);
        rsp_t o;
        int   s;
        logic popped;
        o = '0;
        popped = 1'b0;
        o.status = STAT_DONE;
        s = model_slot[r.item_id];
        case (r.action)
            ACT_INSERT:
                if (s == 0)
                begin
                    if (model_count >= NUM_IDS)
                        o.status = STAT_FULL;
                    else
                    begin
                        model_count++;
                        model_ids[model_count] = r.item_id;
                        model_keys[model_count] = r.priority_req;
                        model_slot[r.item_id] = model_count;
                        bubble_up(model_count);
                    end
                end
                else if (r.priority_req < model_keys[s])
                begin
                    model_keys[s] = r.priority_req;
                    bubble_up(s);
                end
                else
                    o.status = STAT_NOTLOW;
            ACT_REMOVE:
                if (s == 0)
                    o.status = STAT_ABSENT;
                else
                    drop_slot(s);
            ACT_POP:
                if (model_count == 0)
                    o.status = STAT_ABSENT;
                else
                begin
                    popped = 1'b1;
                    o.min_id = model_ids[1];
                    o.min_priority = model_keys[1];
                    drop_slot(1);
                end
            default:
                if (model_count == 0)
                    o.status = STAT_ABSENT;
        endcase
        if (!popped && model_count > 0)
        begin
            o.min_id = model_ids[1];
            o.min_priority = model_keys[1];
        end
        o.is_empty = (model_count == 0);
        o.entry_count = model_count[CNT_W-1:0];
        return o;
    endfunction

    task automatic send_beat(logic [1:0] act, logic [ID_W-1:0] id, logic [KEY_WIDTH-1:0] key);
        req_t r;
        r.action = act;
        r.item_id = id;
        r.priority_req = key;
        while (idle_on && $urandom_range(99) < 16)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsps = {expected_rsps, heap_response(r)};
        beats_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [KEY_WIDTH-1:0] random_key();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return $urandom;
            2: return 32'hFFFF_FFF0 | $urandom_range(15);
            default: return $urandom_range(1000);
        endcase
    endfunction

    task automatic test_directed();
        send_beat(ACT_PEEK, 8'd0, 32'd0);
        send_beat(ACT_POP, 8'd0, 32'd0);
        send_beat(ACT_REMOVE, 8'd5, 32'd0);
        send_beat(ACT_INSERT, 8'd255, 32'hFFFF_FFFF);
        send_beat(ACT_INSERT, 8'd0, 32'h0001_0000);
        send_beat(ACT_INSERT, 8'd7, 32'h0001_0000);
        send_beat(ACT_INSERT, 8'd9, 32'h0001_0000);
        send_beat(ACT_INSERT, 8'd255, 32'hFFFF_FFFF);
        send_beat(ACT_INSERT, 8'd255, 32'h0000_0000);
        send_beat(ACT_INSERT, 8'd7, 32'h0002_0000);
        send_beat(ACT_PEEK, 8'hAA, 32'h5555_5555);
        send_beat(ACT_REMOVE, 8'd0, 32'd0);
        send_beat(ACT_REMOVE, 8'd0, 32'd0);
        send_beat(ACT_POP, 8'd0, 32'd0);
        send_beat(ACT_POP, 8'd0, 32'd0);
        send_beat(ACT_POP, 8'd0, 32'd0);
        send_beat(ACT_POP, 8'd0, 32'd0);
        send_beat(ACT_PEEK, 8'd0, 32'd0);
        wait_drained();
    endtask

    task automatic test_full_heap();
        for (int i = 0; i < NUM_IDS; i++)
            send_beat(ACT_INSERT, i[ID_W-1:0], $urandom);
        send_beat(ACT_INSERT, 8'd3, 32'hFFFF_FFFF);
        send_beat(ACT_PEEK, 8'd0, 32'd0);
        while (model_count > 0)
            send_beat(ACT_POP, 8'd0, 32'd0);
        wait_drained();
    endtask

    task automatic test_random(int n, bit quiet);
        int r;
        idle_on = !quiet;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_beat(ACT_INSERT,
                          ID_W'($urandom_range(model_count > 100 ? 255 : 63)),
                          random_key());
            else if (r < 65)
                send_beat(ACT_REMOVE, ID_W'($urandom_range(255)), $urandom);
            else if (r < 90)
                send_beat(ACT_POP, ID_W'($urandom_range(255)), $urandom);
            else
                send_beat(ACT_PEEK, ID_W'($urandom_range(255)), $urandom);
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        hold_rsp = 1'b1;
        for (int i = 0; i < 40; i++)
            send_beat(ACT_INSERT, ID_W'($urandom_range(255)), random_key());
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_rsp)
        begin
            rsp_stall <= 1'b1;
            hold_cycles--;
            if (hold_cycles <= 0)
                hold_rsp = 1'b0;
        end
        else
            rsp_stall <= idle_on && ($urandom_range(99) < 16);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rsp_valid && !rsp_stall)
        begin
            rsps_seen++;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected response beat %p", rsp);
            end
            else
            begin
                rsp_t e;
                e = expected_rsps.pop_front();
                if (rsp.status !== e.status || rsp.min_id !== e.min_id ||
                    rsp.min_priority !== e.min_priority ||
                    rsp.is_empty !== e.is_empty || rsp.entry_count !== e.entry_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", e, rsp);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_IDS; i++)
            model_slot[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_heap();
        test_backpressure();
        test_random(300, 1'b1);
        test_random(480, 1'b0);
        $display("Sent %0d beats and checked %0d responses, including a full heap,",
                 beats_sent, rsps_seen);
        $display("a long response hold-off and random insert, remove, pop and peek traffic.");
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
